// ===== rtl/fir_tp_pkg.sv =====
`default_nettype none

package fir_tp_pkg;

	localparam int IN_BITS      = 16;
	localparam int OUT_BITS     = 40;
	localparam int TAP_IDX_BITS = 6;
	localparam int SHIFT_BITS   = 5;

	localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 5'd8;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	typedef struct packed {
		logic                  shift_en;
		logic [SHIFT_BITS-1:0] shift_amt;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/fir_filter_truncated_products_top.sv =====
// Direct-form FIR filter with per-product floor truncation.
// The input channel (in_valid, in_stall, req_type, tap_index, value) carries
// two kinds of beat. A coefficient beat (req_type high) loads one tap in the
// cycle it is accepted and gives no result; a tap index past the filter is
// ignored. A sample beat shifts the delay line and starts one filter pass.
// Each cell multiplies its sample by its coefficient and shifts the product
// right by product_shift, then a partial sum walks the cell chain, one cell
// per cycle, and the total passes through a result register and an output
// register onto the output channel (out_valid, out_stall, filtered).
// in_stall rises when a sample beat is accepted and falls once its result
// moves into the output register; a coefficient beat does not raise it.
// The output register frees the chain: a new beat is taken while a finished
// result waits there, and a result that has nowhere to go holds off input.
// When the receiver stalls, out_valid and filtered hold.
// product_shift is written through cfg_we and cfg_wdata while idle; the user
// is bound to it, as the block does not enforce it. Reset clears the delay
// line and coefficients to zero, sets product_shift to 8, empties the output.
`default_nettype none

module fir_filter_truncated_products_top #(
	parameter int TAPS        = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_valid,
	output logic                                    in_stall,
	input  wire                                     req_type,
	input  wire         [fir_tp_pkg::TAP_IDX_BITS-1:0] tap_index,
	input  wire  signed [fir_tp_pkg::IN_BITS-1:0]      value,
	output logic                                    out_valid,
	input  wire                                     out_stall,
	output logic signed [fir_tp_pkg::OUT_BITS-1:0]     filtered,
	input  wire                                     cfg_we,
	input  wire         [fir_tp_pkg::SHIFT_BITS-1:0]   cfg_wdata
);

	logic                                  in_acc;
	logic                                  samp_acc;
	logic                                  coef_acc;
	logic signed [SAMPLE_BITS-1:0]         in_samp;
	logic        [fir_tp_pkg::SHIFT_BITS-1:0] shift_q;
	logic                                  busy_q;
	logic                                  start_s1;
	logic                                  start_s2;
	logic                                  res_valid_q;
	logic        [fir_tp_pkg::OUT_BITS-1:0]   res_q;
	logic                                  out_valid_q;
	logic        [fir_tp_pkg::OUT_BITS-1:0]   filtered_q;
	logic                                  out_free;
	logic                                  res_move;
	fir_tp_pkg::cell_ctrl_t                ctrl;

	logic [TAPS:0]                              tok_w;
	logic [TAPS:0][fir_tp_pkg::OUT_BITS-1:0]    sum_w;
	logic [TAPS-1:0][SAMPLE_BITS-1:0]           samp_w;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign samp_acc = in_acc && (req_type == fir_tp_pkg::REQ_SAMPLE);
	assign coef_acc = in_acc && (req_type == fir_tp_pkg::REQ_COEF);

	generate
		if (SAMPLE_BITS <= fir_tp_pkg::IN_BITS) begin : g_narrow
			assign in_samp = value[SAMPLE_BITS-1:0];
		end else begin : g_wide
			assign in_samp = {{(SAMPLE_BITS - fir_tp_pkg::IN_BITS){value[fir_tp_pkg::IN_BITS-1]}},
			                  value};
		end
	endgenerate

	assign ctrl.shift_en  = samp_acc;
	assign ctrl.shift_amt = shift_q;

	assign samp_w[0] = in_samp;
	assign tok_w[0]  = start_s2;
	assign sum_w[0]  = '0;

	generate
		for (genvar k = 0; k < TAPS; k++) begin : g_cell
			logic coef_we;
			assign coef_we = coef_acc && (32'(tap_index) == k);

			if (k < TAPS - 1) begin : g_mid
				fir_tp_cell #(
					.SAMPLE_BITS(SAMPLE_BITS)
				) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.sample_in  (samp_w[k]),
					.sample_out (samp_w[k+1]),
					.coef_we    (coef_we),
					.coef_in    (in_samp),
					.token_in   (tok_w[k]),
					.sum_in     (sum_w[k]),
					.token_out  (tok_w[k+1]),
					.sum_out    (sum_w[k+1])
				);
			end else begin : g_last
				fir_tp_cell #(
					.SAMPLE_BITS(SAMPLE_BITS)
				) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.sample_in  (samp_w[k]),
					.sample_out (),
					.coef_we    (coef_we),
					.coef_in    (in_samp),
					.token_in   (tok_w[k]),
					.sum_in     (sum_w[k]),
					.token_out  (tok_w[k+1]),
					.sum_out    (sum_w[k+1])
				);
			end
		end
	endgenerate

	assign out_free = !out_valid_q || !out_stall;
	assign res_move = res_valid_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= fir_tp_pkg::SHIFT_RESET;
			busy_q      <= 1'b0;
			start_s1    <= 1'b0;
			start_s2    <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				shift_q <= cfg_wdata;
			end
			start_s1 <= samp_acc;
			start_s2 <= start_s1;
			if (samp_acc) begin
				busy_q <= 1'b1;
			end else if (res_move) begin
				busy_q <= 1'b0;
			end
			if (tok_w[TAPS]) begin
				res_valid_q <= 1'b1;
			end else if (res_move) begin
				res_valid_q <= 1'b0;
			end
			if (res_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_w[TAPS]) begin
			res_q <= sum_w[TAPS];
		end
		if (res_move) begin
			filtered_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	a_one_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_w))
		else $error("More than one partial sum in the tap chain.");

	a_pending_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q || start_s1 || start_s2) |-> busy_q)
		else $error("Input taken while a filter pass is still open.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		tok_w[TAPS] |-> !res_valid_q)
		else $error("Chain result arrived while the previous one still waits.");

endmodule

`default_nettype wire

// ===== rtl/fir_tp_cell.sv =====
`default_nettype none

module fir_tp_cell #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  fir_tp_pkg::cell_ctrl_t               ctrl,
	input  wire  signed [SAMPLE_BITS-1:0]        sample_in,
	output logic signed [SAMPLE_BITS-1:0]        sample_out,
	input  wire                                  coef_we,
	input  wire  signed [SAMPLE_BITS-1:0]        coef_in,
	input  wire                                  token_in,
	input  wire         [fir_tp_pkg::OUT_BITS-1:0] sum_in,
	output logic                                 token_out,
	output logic        [fir_tp_pkg::OUT_BITS-1:0] sum_out
);

	localparam int PROD_BITS = 2 * SAMPLE_BITS;
	localparam int EXT_BITS  = (PROD_BITS > fir_tp_pkg::OUT_BITS) ? PROD_BITS
	                                                              : fir_tp_pkg::OUT_BITS;

	logic signed [SAMPLE_BITS-1:0]          sample_q;
	logic signed [SAMPLE_BITS-1:0]          coef_q;
	logic signed [PROD_BITS-1:0]            prod;
	logic signed [EXT_BITS-1:0]             prod_ext;
	logic signed [EXT_BITS-1:0]             prod_shifted;
	logic        [fir_tp_pkg::OUT_BITS-1:0] prod_q;
	logic                                   token_q;
	logic        [fir_tp_pkg::OUT_BITS-1:0] sum_q;

	assign prod         = sample_q * coef_q;
	assign prod_ext     = EXT_BITS'(prod);
	assign prod_shifted = prod_ext >>> ctrl.shift_amt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			coef_q   <= '0;
			token_q  <= 1'b0;
		end else begin
			if (ctrl.shift_en) begin
				sample_q <= sample_in;
			end
			if (coef_we) begin
				coef_q <= coef_in;
			end
			token_q <= token_in;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_shifted[fir_tp_pkg::OUT_BITS-1:0];
		if (token_in) begin
			sum_q <= sum_in + prod_q;
		end
	end

	assign sample_out = sample_q;
	assign token_out  = token_q;
	assign sum_out    = sum_q;

endmodule

`default_nettype wire

// ===== sim/tb_fir_filter_truncated_products_top.sv =====
`timescale 1ns / 1ps

module tb_fir_filter_truncated_products_top;

	localparam int TAPS          = 64;
	localparam int SETTLE_CYCLES = TAPS + 8;
	localparam int LONG_HOLD     = 400;

	logic                                         clk = 1'b0;
	logic                                         arst_n;
	logic                                         in_valid;
	logic                                         in_stall;
	logic                                         req_type;
	logic        [fir_tp_pkg::TAP_IDX_BITS-1:0]   tap_index;
	logic signed [fir_tp_pkg::IN_BITS-1:0]        value;
	logic                                         out_valid;
	logic                                         out_stall;
	logic signed [fir_tp_pkg::OUT_BITS-1:0]       filtered;
	logic                                         cfg_we;
	logic        [fir_tp_pkg::SHIFT_BITS-1:0]     cfg_wdata;

	logic signed [fir_tp_pkg::IN_BITS-1:0]    coef_mem [TAPS];
	logic signed [fir_tp_pkg::IN_BITS-1:0]    sample_hist [TAPS];
	logic        [fir_tp_pkg::SHIFT_BITS-1:0] shift_cfg;
	logic signed [fir_tp_pkg::OUT_BITS-1:0]   expected_sums [$];
	int                                       mismatches;
	bit                                       tx_idle_en;
	bit                                       rx_idle_en;
	int                                       hold_req;
	int                                       hold_left;
	int                                       stall_left;

	fir_filter_truncated_products_top #(
		.TAPS       (TAPS),
		.SAMPLE_BITS(16)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.tap_index(tap_index),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered (filtered),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic signed [fir_tp_pkg::OUT_BITS-1:0] filter_sample(
		input logic signed [fir_tp_pkg::IN_BITS-1:0] s);
		logic signed [fir_tp_pkg::OUT_BITS-1:0]  acc;
		logic signed [2*fir_tp_pkg::IN_BITS-1:0] prod;
		for (int i = TAPS - 1; i > 0; i--)
			sample_hist[i] = sample_hist[i-1];
		sample_hist[0] = s;
		acc = '0;
		for (int i = 0; i < TAPS; i++) begin
			prod = coef_mem[i] * sample_hist[i];
			acc = acc + (prod >>> shift_cfg);
		end
		return acc;
	endfunction

	function automatic logic signed [fir_tp_pkg::IN_BITS-1:0] rand_value();
		case ($urandom_range(0, 11))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_beat(input logic rt, input logic [fir_tp_pkg::TAP_IDX_BITS-1:0] idx,
		input logic signed [fir_tp_pkg::IN_BITS-1:0] v);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid  = 1'b1;
		req_type  = rt;
		tap_index = idx;
		value     = v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (rt == fir_tp_pkg::REQ_COEF) begin
			if (idx < TAPS)
				coef_mem[idx] = v;
		end else begin
			expected_sums.insert(expected_sums.size(), filter_sample(v));
		end
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (expected_sums.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_product_shift(input logic [fir_tp_pkg::SHIFT_BITS-1:0] s);
		wait_idle();
		cfg_we    = 1'b1;
		cfg_wdata = s;
		@(negedge clk);
		cfg_we    = 1'b0;
		shift_cfg = s;
	endtask

	task automatic test_reset_state();
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd0, 16'sh7fff);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd63, 16'sh8000);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd21, '1);
	endtask

	task automatic test_coefficient_extremes();
		send_beat(fir_tp_pkg::REQ_COEF, 6'd0, 16'sh8000);
		send_beat(fir_tp_pkg::REQ_COEF, 6'd1, 16'sh7fff);
		send_beat(fir_tp_pkg::REQ_COEF, 6'd62, 16'sh7fff);
		send_beat(fir_tp_pkg::REQ_COEF, 6'd63, 16'sh8000);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd63, 16'sh8000);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd0, 16'sh8000);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd42, 16'sh7fff);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd42, '0);
	endtask

	task automatic test_shift_extremes();
		set_product_shift('0);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd5, 16'sh8000);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd5, 16'sh7fff);
		set_product_shift('1);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd10, 16'sh8000);
		send_beat(fir_tp_pkg::REQ_SAMPLE, 6'd10, 16'sh0001);
	endtask

	task automatic test_random_traffic(input logic [fir_tp_pkg::SHIFT_BITS-1:0] s,
		input int n);
		set_product_shift(s);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				send_beat(fir_tp_pkg::REQ_COEF, 6'($urandom_range(0, TAPS - 1)),
					rand_value());
			else
				send_beat(fir_tp_pkg::REQ_SAMPLE, 6'($urandom), rand_value());
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		hold_req = LONG_HOLD;
		repeat (12)
			send_beat(fir_tp_pkg::REQ_SAMPLE, 6'($urandom), rand_value());
		wait_idle();
	endtask

	task automatic test_streaming();
		wait_idle();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_traffic(5'($urandom_range(0, 31)), 250);
	endtask

	// The receiver stalls in short random bursts, or for a long hold on request.
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_sums.size() == 0) begin
				$error("filtered beat with none expected: actual %0d", filtered);
				mismatches++;
			end else begin
				if (filtered !== expected_sums[0]) begin
					$error("filtered mismatch: expected %0d, actual %0d",
						expected_sums[0], filtered);
					mismatches++;
				end
				void'(expected_sums.pop_front());
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		req_type   = fir_tp_pkg::REQ_SAMPLE;
		tap_index  = '0;
		value      = '0;
		out_stall  = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		shift_cfg  = fir_tp_pkg::SHIFT_RESET;
		mismatches = 0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		hold_req   = 0;
		hold_left  = 0;
		stall_left = 0;
		for (int i = 0; i < TAPS; i++) begin
			coef_mem[i]    = '0;
			sample_hist[i] = '0;
		end
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_coefficient_extremes();
		test_shift_extremes();
		test_random_traffic('0, 220);
		test_random_traffic('1, 220);
		test_random_traffic(fir_tp_pkg::SHIFT_RESET, 220);
		test_random_traffic(5'd1, 220);
		test_backpressure();
		test_random_traffic(5'd16, 220);
		test_random_traffic(5'($urandom_range(0, 31)), 220);
		test_streaming();
		wait_idle();

		if (mismatches == 0)
			$display("tb_fir_filter_truncated_products_top passed");
		else
			$display("tb_fir_filter_truncated_products_top failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_fir_filter_truncated_products_top failed");
		$finish;
	end

endmodule
